### hw/rtl/reb_pkg.sv
// Shared types and constants for the rotary encoder / button decoder.
// No dependencies; used by rotary_encoder_button_decoder.
`timescale 1ns / 1ps
`default_nettype none

package reb_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_ACTIVE_LEVEL   = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_LIMIT = 2'd1;
    localparam logic [1:0] REG_SHORT_LIMIT    = 2'd2;
    localparam logic [1:0] REG_LONG_LIMIT     = 2'd3;

    // register reset values
    localparam logic        ACTIVE_LEVEL_RST   = 1'b0;
    localparam logic [2:0]  DEBOUNCE_LIMIT_RST = 3'd2;
    localparam logic [15:0] SHORT_LIMIT_RST    = 16'd36;
    localparam logic [15:0] LONG_LIMIT_RST     = 16'd300;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_CW   = 2'd1,
        STEP_CCW  = 2'd2
    } step_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_UP     = 3'd2,
        EV_SINGLE = 3'd3,
        EV_DOUBLE = 3'd4,
        EV_LSTART = 3'd5,
        EV_LHOLD  = 3'd6
    } event_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PRESSED  = 3'd1,
        PH_WAIT     = 3'd2,
        PH_PRESSED2 = 3'd3,
        PH_LONG     = 3'd4
    } phase_t;

    // one result beat
    typedef struct packed {
        logic [7:0]  tap_count;
        logic        repeat_flag;
        event_t      button_event;
        logic [15:0] position;
        step_t       encoder_step;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/rotary_encoder_button_decoder.sv
// Rotary encoder detent counter with debounced multi-click button decoder.
// Depends on reb_pkg.
//
// Result beats are registered in the output register (or skid entry).
// Throughput: one input beat per cycle while s_tready is high; all state
//   updates in one pass of logic between state and result registers.
// An output register plus a one-entry skid buffer let input beats keep
//   arriving while a result waits; s_tready drops only when both are full.
// Reset (rst_n low, async): state cleared, debounced level = not pressed,
//   registers at their defaults, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module rotary_encoder_button_decoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    // sample ticks
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] a_level, [1] b_level, [2] button_level, [7:3] zero
    input  wire logic [reb_pkg::IN_TDATA_W-1:0] s_tdata,

    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] encoder_step, [17:2] position, [20:18] button_event,
    // [21] repeat_flag, [29:22] tap_count, [31:30] zero
    output logic [reb_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic        active_level_reg;
    logic [2:0]  debounce_limit_reg;
    logic [15:0] short_limit_reg;
    logic [15:0] long_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg   <= reb_pkg::ACTIVE_LEVEL_RST;
            debounce_limit_reg <= reb_pkg::DEBOUNCE_LIMIT_RST;
            short_limit_reg    <= reb_pkg::SHORT_LIMIT_RST;
            long_limit_reg     <= reb_pkg::LONG_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                reb_pkg::REG_ACTIVE_LEVEL:   active_level_reg   <= cfg_data[0];
                reb_pkg::REG_DEBOUNCE_LIMIT: debounce_limit_reg <= cfg_data[2:0];
                reb_pkg::REG_SHORT_LIMIT:    short_limit_reg    <= cfg_data;
                reb_pkg::REG_LONG_LIMIT:     long_limit_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // decoder state
    // ------------------------------------------------------------------
    logic              prev_a_reg,       prev_a_next;
    logic [15:0]       pos_reg,          pos_next;
    logic              deb_level_reg,    deb_level_next;
    logic [2:0]        deb_cnt_reg,      deb_cnt_next;
    reb_pkg::phase_t   phase_reg,        phase_next;
    logic [15:0]       tick_reg,         tick_next;
    logic [7:0]        taps_reg,         taps_next;
    reb_pkg::result_t  result;

    logic        in_a;
    logic        in_b;
    logic        in_btn;
    logic        accept;
    logic [2:0]  deb_cnt_inc;
    logic [15:0] tick_inc;
    logic        pressed;

    assign in_a   = s_tdata[0];
    assign in_b   = s_tdata[1];
    assign in_btn = s_tdata[2];
    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        prev_a_next    = prev_a_reg;
        pos_next       = pos_reg;
        deb_level_next = deb_level_reg;
        deb_cnt_next   = deb_cnt_reg;
        phase_next     = phase_reg;
        taps_next      = taps_reg;
        deb_cnt_inc    = deb_cnt_reg + 3'd1;
        result.encoder_step = reb_pkg::STEP_NONE;
        result.button_event = reb_pkg::EV_NONE;
        result.repeat_flag  = 1'b0;

        // encoder: count on the falling edge of A, B gives direction
        if (in_a != prev_a_reg)
        begin
            prev_a_next = in_a;
            if (!in_a)
            begin
                if (in_b)
                begin
                    result.encoder_step = reb_pkg::STEP_CW;
                    pos_next = pos_reg + 16'd1;
                end
                else
                begin
                    result.encoder_step = reb_pkg::STEP_CCW;
                    pos_next = pos_reg - 16'd1;
                end
            end
        end

        // tick timer runs in every phase but idle
        tick_inc  = (phase_reg != reb_pkg::PH_IDLE) ? tick_reg + 16'd1 : tick_reg;
        tick_next = tick_inc;

        // debounce
        if (in_btn != deb_level_reg)
        begin
            if (deb_cnt_inc >= debounce_limit_reg)
            begin
                deb_level_next = in_btn;
                deb_cnt_next   = 3'd0;
            end
            else
            begin
                deb_cnt_next = deb_cnt_inc;
            end
        end
        else
        begin
            deb_cnt_next = 3'd0;
        end

        pressed = (deb_level_next == active_level_reg);

        // button phase machine
        case (phase_reg)
            reb_pkg::PH_IDLE:
            begin
                if (pressed)
                begin
                    result.button_event = reb_pkg::EV_DOWN;
                    tick_next  = 16'd0;
                    taps_next  = 8'd1;
                    phase_next = reb_pkg::PH_PRESSED;
                end
            end
            reb_pkg::PH_PRESSED:
            begin
                if (!pressed)
                begin
                    result.button_event = reb_pkg::EV_UP;
                    tick_next  = 16'd0;
                    phase_next = reb_pkg::PH_WAIT;
                end
                else if (tick_inc > long_limit_reg)
                begin
                    result.button_event = reb_pkg::EV_LSTART;
                    phase_next = reb_pkg::PH_LONG;
                end
            end
            reb_pkg::PH_WAIT:
            begin
                if (pressed)
                begin
                    result.button_event = reb_pkg::EV_DOWN;
                    result.repeat_flag  = 1'b1;
                    taps_next  = taps_reg + 8'd1;
                    tick_next  = 16'd0;
                    phase_next = reb_pkg::PH_PRESSED2;
                end
                else if (tick_inc > short_limit_reg)
                begin
                    // three or more taps end with no click event
                    if (taps_reg == 8'd1)
                        result.button_event = reb_pkg::EV_SINGLE;
                    else if (taps_reg == 8'd2)
                        result.button_event = reb_pkg::EV_DOUBLE;
                    phase_next = reb_pkg::PH_IDLE;
                end
            end
            reb_pkg::PH_PRESSED2:
            begin
                if (!pressed)
                begin
                    result.button_event = reb_pkg::EV_UP;
                    if (tick_inc < short_limit_reg)
                    begin
                        tick_next  = 16'd0;
                        phase_next = reb_pkg::PH_WAIT;
                    end
                    else
                    begin
                        phase_next = reb_pkg::PH_IDLE;
                    end
                end
            end
            reb_pkg::PH_LONG:
            begin
                if (pressed)
                begin
                    result.button_event = reb_pkg::EV_LHOLD;
                end
                else
                begin
                    result.button_event = reb_pkg::EV_UP;
                    phase_next = reb_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = reb_pkg::PH_IDLE;
            end
        endcase

        result.position  = pos_next;
        result.tap_count = taps_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg    <= 1'b0;
            pos_reg       <= 16'd0;
            deb_level_reg <= ~reb_pkg::ACTIVE_LEVEL_RST;
            deb_cnt_reg   <= 3'd0;
            phase_reg     <= reb_pkg::PH_IDLE;
            tick_reg      <= 16'd0;
            taps_reg      <= 8'd0;
        end
        else if (accept)
        begin
            prev_a_reg    <= prev_a_next;
            pos_reg       <= pos_next;
            deb_level_reg <= deb_level_next;
            deb_cnt_reg   <= deb_cnt_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            taps_reg      <= taps_next;
        end
    end

    // ------------------------------------------------------------------
    // result register + skid entry
    // ------------------------------------------------------------------
    logic             out_valid_reg;
    logic             skid_valid_reg;
    reb_pkg::result_t out_data_reg;
    reb_pkg::result_t skid_data_reg;
    logic             pop;

    assign s_tready = !skid_valid_reg;
    assign pop      = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // no beat accepted while the skid entry is full
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= result;
            else
                out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(reb_pkg::OUT_TDATA_W - $bits(reb_pkg::result_t)){1'b0}},
                       out_data_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // skid entry only fills behind a pending result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without a pending result");

    // debounce count only advances to values below the limit, so never reaches 7
    a_deb_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        deb_cnt_reg != 3'd7)
        else $error("debounce count out of range");

    // long press is entered only from the first pressed phase
    a_long_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == reb_pkg::PH_LONG && $past(phase_reg) != reb_pkg::PH_LONG)
        |-> ($past(phase_reg) == reb_pkg::PH_PRESSED))
        else $error("long press entered from wrong phase");

endmodule

`default_nettype wire
